[rtl/core/ifsd_pkg.sv]
// ifsd_pkg: shared types, constants and decode functions for the imu frame sync decoder
// no dependencies; used by every module under rtl/core except ifsd_byte_cell

package ifsd_pkg;

    // frame framing bytes
    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACC = 8'h51;
    localparam logic [7:0] TYPE_GYR = 8'h52;
    localparam logic [7:0] TYPE_ANG = 8'h53;

    // payload length in bytes, and its counter width
    localparam int PAYLOAD_BYTES = 8;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES);
    localparam int NUM_WORDS     = PAYLOAD_BYTES / 2;

    // field widths
    localparam int KIND_W = 2;
    localparam int AXIS_W = 25;
    localparam int TEMP_W = 17;
    localparam int SCALE_W = 10;

    // frame kind codes
    localparam logic [KIND_W-1:0] KIND_ACC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GYR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANG = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    // temperature: floor(64*a/85) = floor(a*TEMP_RECIP / 2^TEMP_SHIFT), a <= 2^15
    localparam int              TEMP_MAG_W  = 17;
    localparam int              TEMP_RECIP_W = 23;
    localparam logic [TEMP_RECIP_W-1:0] TEMP_RECIP = 23'd6316129;
    localparam int              TEMP_SHIFT  = 23;
    localparam int              TEMP_PROD_W = TEMP_MAG_W + TEMP_RECIP_W;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET_Q8 = 17'sd9280;

    typedef logic signed [15:0] t_word;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_TYPE,
        ST_PAYLOAD,
        ST_CHECK
    } t_sync_state;

    // control from the sync fsm to the datapath
    typedef struct packed {
        logic              shift;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } t_sync_ctrl;

    // type byte to kind, KIND_BAD when not a known type
    function automatic logic [KIND_W-1:0] type_to_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            TYPE_ACC: k = KIND_ACC;
            TYPE_GYR: k = KIND_GYR;
            TYPE_ANG: k = KIND_ANG;
            default:  k = KIND_BAD;
        endcase
        return k;
    endfunction

    // per-kind axis scale to q13
    function automatic logic [SCALE_W-1:0] kind_to_scale(input logic [KIND_W-1:0] k);
        logic [SCALE_W-1:0] s;
        case (k)
            KIND_ACC: s = 10'd4;
            KIND_GYR: s = 10'd500;
            KIND_ANG: s = 10'd45;
            default:  s = 10'd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/ifsd_byte_cell.sv]
// ifsd_byte_cell: one payload byte stage of the shift chain
// depends on nothing; instantiated in a row by the top level

module ifsd_byte_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[rtl/core/ifsd_sync_fsm.sv]
// ifsd_sync_fsm: header hunt and byte position tracking
// depends on ifsd_pkg

module ifsd_sync_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output ifsd_pkg::t_sync_ctrl o_ctrl
);

    ifsd_pkg::t_sync_state             r_state, n_state;
    logic [ifsd_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [ifsd_pkg::KIND_W-1:0]       r_kind, n_kind;
    logic [ifsd_pkg::KIND_W-1:0]       type_kind;

    assign type_kind = ifsd_pkg::type_to_kind(i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ifsd_pkg::ST_HUNT;
            r_cnt   <= '0;
            r_kind  <= ifsd_pkg::KIND_ACC;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        o_ctrl  = '{shift: 1'b0, emit: 1'b0, kind: r_kind};
        case (r_state)
            ifsd_pkg::ST_HUNT: begin
                if (i_accept && i_byte == ifsd_pkg::HDR_BYTE) begin
                    n_state = ifsd_pkg::ST_TYPE;
                end
            end
            ifsd_pkg::ST_TYPE: begin
                if (i_accept) begin
                    if (type_kind != ifsd_pkg::KIND_BAD) begin
                        n_state = ifsd_pkg::ST_PAYLOAD;
                        n_kind  = type_kind;
                        n_cnt   = '0;
                    end else if (i_byte == ifsd_pkg::HDR_BYTE) begin
                        // bad type, but this byte is itself a header
                        n_state = ifsd_pkg::ST_TYPE;
                    end else begin
                        n_state = ifsd_pkg::ST_HUNT;
                    end
                end
            end
            ifsd_pkg::ST_PAYLOAD: begin
                o_ctrl.shift = 1'b1;
                if (i_accept) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == ifsd_pkg::CNT_W'(ifsd_pkg::PAYLOAD_BYTES - 1)) begin
                        n_state = ifsd_pkg::ST_CHECK;
                    end
                end
            end
            ifsd_pkg::ST_CHECK: begin
                // checksum byte closes the frame, value ignored
                o_ctrl.emit = 1'b1;
                if (i_accept) begin
                    n_state = ifsd_pkg::ST_HUNT;
                end
            end
            default: begin
                n_state = ifsd_pkg::ST_HUNT;
            end
        endcase
    end

endmodule

[rtl/core/ifsd_scale.sv]
// ifsd_scale: two-stage scaling pipe, axis multiply and temperature conversion
// depends on ifsd_pkg

module ifsd_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [ifsd_pkg::KIND_W-1:0]        i_kind,
    input  ifsd_pkg::t_word                    i_word [ifsd_pkg::NUM_WORDS],
    output logic                               o_in_ready,
    input  logic                               i_out_ready,
    output logic                               o_valid,
    output logic [ifsd_pkg::KIND_W-1:0]        o_kind,
    output logic signed [ifsd_pkg::AXIS_W-1:0] o_axis [3],
    output logic signed [ifsd_pkg::TEMP_W-1:0] o_temp
);

    localparam int PROD_W = 16 + ifsd_pkg::SCALE_W + 1;

    logic                                   adv1, adv2;
    logic [ifsd_pkg::SCALE_W-1:0]           scale;
    logic signed [PROD_W-1:0]               axis_prod [3];
    logic [ifsd_pkg::TEMP_MAG_W-1:0]        temp_ext, temp_mag;
    logic [ifsd_pkg::TEMP_PROD_W-1:0]       temp_prod;
    logic [ifsd_pkg::TEMP_MAG_W-1:0]        temp_q;
    logic signed [ifsd_pkg::TEMP_W-1:0]     temp_signed;

    // stage 1
    logic                                   r_v1;
    logic [ifsd_pkg::KIND_W-1:0]            r_kind1;
    logic signed [ifsd_pkg::AXIS_W-1:0]     r_axis1 [3];
    logic                                   r_tneg1;
    logic [ifsd_pkg::TEMP_PROD_W-1:0]       r_tprod1;

    // stage 2 (output register)
    logic                                   r_v2;
    logic [ifsd_pkg::KIND_W-1:0]            r_kind2;
    logic signed [ifsd_pkg::AXIS_W-1:0]     r_axis2 [3];
    logic signed [ifsd_pkg::TEMP_W-1:0]     r_temp2;

    assign adv2       = !r_v2 || i_out_ready;
    assign adv1       = !r_v1 || adv2;
    assign o_in_ready = adv1;

    assign scale = ifsd_pkg::kind_to_scale(i_kind);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            axis_prod[k] = PROD_W'(i_word[k]) * $signed({1'b0, scale});
        end
    end

    // magnitude of the temperature word, then reciprocal multiply
    assign temp_ext  = {i_word[3][15], i_word[3]};
    assign temp_mag  = i_word[3][15] ? (~temp_ext + 1'b1) : temp_ext;
    assign temp_prod = ifsd_pkg::TEMP_PROD_W'(temp_mag) * ifsd_pkg::TEMP_PROD_W'(ifsd_pkg::TEMP_RECIP);

    assign temp_q      = r_tprod1[ifsd_pkg::TEMP_SHIFT +: ifsd_pkg::TEMP_MAG_W];
    assign temp_signed = r_tneg1 ? $signed(~temp_q + 1'b1) : $signed(temp_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_load;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_load) begin
            r_kind1  <= i_kind;
            r_tneg1  <= i_word[3][15];
            r_tprod1 <= temp_prod;
            for (int k = 0; k < 3; k++) begin
                r_axis1[k] <= axis_prod[k][ifsd_pkg::AXIS_W-1:0];
            end
        end
        if (adv2 && r_v1) begin
            r_kind2 <= r_kind1;
            r_temp2 <= temp_signed + ifsd_pkg::TEMP_OFFSET_Q8;
            for (int k = 0; k < 3; k++) begin
                r_axis2[k] <= r_axis1[k];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_kind  = r_kind2;
    assign o_axis  = r_axis2;
    assign o_temp  = r_temp2;

endmodule

[rtl/core/imu_frame_sync_decoder_core.sv]
// imu_frame_sync_decoder_core: top level of the 11-byte imu frame decoder
// depends on ifsd_pkg, ifsd_sync_fsm, ifsd_byte_cell, ifsd_scale
//
// throughput: one input word per cycle while the scaling pipe accepts input,
// one frame result per 11 input words at most; after the checksum word is taken the
// result passes the multiply stage, then the sign/offset stage into the output register
// reset: synchronous active-low; returns to header hunt and empties the result pipe

module imu_frame_sync_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // [24:0] axis_x, [49:25] axis_y,
                                          // [74:50] axis_z, [91:75] temperature_q8,
                                          // [95:92] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] frame_kind
);

    localparam int NB = ifsd_pkg::PAYLOAD_BYTES;

    logic                                s_accept;
    logic                                in_ready;
    ifsd_pkg::t_sync_ctrl                ctrl;
    logic [7:0]                          cell_q [NB];
    logic [7:0]                          cell_d [NB];
    ifsd_pkg::t_word                     word   [ifsd_pkg::NUM_WORDS];
    logic                                res_valid;
    logic [ifsd_pkg::KIND_W-1:0]         res_kind;
    logic signed [ifsd_pkg::AXIS_W-1:0]  res_axis [3];
    logic signed [ifsd_pkg::TEMP_W-1:0]  res_temp;

    assign o_s_axis_tready = in_ready;
    assign s_accept        = i_s_axis_tvalid && in_ready;

    // header hunt, type decode and byte position
    ifsd_sync_fsm u_sync (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_axis_tdata),
        .o_ctrl   (ctrl)
    );

    // payload shift chain: new bytes enter the top cell and move toward cell 0,
    // so after eight payload words cell 0 holds the first payload byte
    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_cell
            if (g == NB - 1) begin : g_head
                assign cell_d[g] = i_s_axis_tdata;
            end else begin : g_body
                assign cell_d[g] = cell_q[g + 1];
            end
            ifsd_byte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (s_accept && ctrl.shift),
                .i_byte  (cell_d[g]),
                .o_byte  (cell_q[g])
            );
        end
        // little-endian words from byte pairs
        for (g = 0; g < ifsd_pkg::NUM_WORDS; g++) begin : g_word
            assign word[g] = $signed({cell_q[2*g + 1], cell_q[2*g]});
        end
    endgenerate

    // scaling pipe; it captures the words when the checksum word is taken,
    // so the chain is free for the next frame right away
    ifsd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_accept && ctrl.emit),
        .i_kind      (ctrl.kind),
        .i_word      (word),
        .o_in_ready  (in_ready),
        .i_out_ready (i_m_axis_tready),
        .o_valid     (res_valid),
        .o_kind      (res_kind),
        .o_axis      (res_axis),
        .o_temp      (res_temp)
    );

    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tuser  = res_kind;
    assign o_m_axis_tdata  = {4'b0000, res_temp, res_axis[2], res_axis[1], res_axis[0]};

    // a frame is never closed with an unknown kind
    a_emit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> ctrl.kind != ifsd_pkg::KIND_BAD)
        else $error("frame closed with unknown kind");

    // shifting and emitting never happen in the same position
    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.shift && ctrl.emit))
        else $error("shift and emit both active");

    // temperature stays in the range the conversion allows
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[91:75]) >= -17'sd15392 &&
                             $signed(o_m_axis_tdata[91:75]) <= 17'sd33952))
        else $error("temperature out of range");

    // reset empties the result pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
